// ===== rtl/core/erq_pkg.sv =====
// Package for the event ring queue: sizes, operation codes and the event record type.
package erq_pkg;

   localparam int QUEUE_SIZE = 16;
   localparam int PTR_W      = (QUEUE_SIZE > 2) ? $clog2(QUEUE_SIZE) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_SIZE - 1);

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Packed so that the first field sits in the highest bits.
   typedef struct packed {
      logic signed [15:0] param_b;
      logic signed [15:0] param_a;
      logic        [7:0]  target;
      logic        [7:0]  source;
      logic        [7:0]  ev_type;
   } event_rec_type;

   localparam int REC_W = $bits(event_rec_type);

   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == LAST_PTR) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/event_ring_queue_drop_oldest.sv =====
// Event ring queue that overwrites the oldest record when full.
//
//  Channel  Direction  Contents
//  req_*    in         tuser[1:0] operation; tdata[55:0] type, source, target, param_a, param_b
//  rsp_*    out        tuser[1:0] found, dropped; tdata[55:0] type, source, target, param_a, param_b
//
// One operation is accepted per cycle while req_tready is high. Pointers are updated at acceptance
// and a pop or peek reads the slot memory at that edge into the read stage; the result moves
// into the output register when it is free, the read stage coming from the memory's registered read port.
// Reset clears both pointers and the handshake state; the slots are left as they are.
// A stalled result holds one further operation in the read stage, after which req_tready drops.
module event_ring_queue_drop_oldest
   import erq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [55:0]      req_tdata,   // type, source, target, param_a, param_b
   input  logic [1:0]       req_tuser,   // operation
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [55:0]      rsp_tdata,   // type, source, target, param_a, param_b
   output logic [1:0]       rsp_tuser    // found, dropped
);

   event_rec_type mem [QUEUE_SIZE];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             pend_ff, pend_in;
   logic             pend_found_ff, pend_dropped_ff;
   event_rec_type    rdata_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [55:0]      rsp_data_ff;
   logic [1:0]       rsp_user_ff;

   logic             accept;
   logic             out_free;
   logic             move;
   op_type           op;
   logic             empty;
   logic             full;
   logic             found_now;
   logic             dropped_now;
   logic [PTR_W-1:0] wr_next;

   assign op       = op_type'(req_tuser);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign move     = pend_ff && out_free;
   assign req_tready = !pend_ff || out_free;
   assign accept   = req_tvalid && req_tready;

   assign wr_next = ptr_advance(wr_ptr_ff);
   assign empty   = (wr_ptr_ff == rd_ptr_ff);
   assign full    = (wr_next == rd_ptr_ff);

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      found_now   = 1'b0;
      dropped_now = 1'b0;
      if (accept) begin
         unique case (op)
            OP_PUSH: begin
               wr_ptr_in = wr_next;
               if (full) begin
                  rd_ptr_in   = ptr_advance(rd_ptr_ff);
                  dropped_now = 1'b1;
               end
            end
            OP_POP: begin
               if (!empty) begin
                  found_now = 1'b1;
                  rd_ptr_in = ptr_advance(rd_ptr_ff);
               end
            end
            OP_PEEK: begin
               found_now = !empty;
            end
            OP_CLEAR: begin
               wr_ptr_in = '0;
               rd_ptr_in = '0;
            end
            default: begin
               wr_ptr_in = wr_ptr_ff;
            end
         endcase
      end
      pend_in      = accept || (pend_ff && !move);
      rsp_valid_in = move || (rsp_valid_ff && !rsp_tready);
   end

   // Slot memory: one write and one registered read per cycle, each on an accepted operation.
   always_ff @(posedge clock) begin
      if (accept && op == OP_PUSH) begin
         mem[wr_ptr_ff] <= event_rec_type'(req_tdata);
      end
      if (accept) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_found_ff   <= found_now;
         pend_dropped_ff <= dropped_now;
      end
      if (move) begin
         rsp_data_ff <= pend_found_ff ? 56'(rdata_ff) : '0;
         rsp_user_ff <= {pend_dropped_ff, pend_found_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
